// File: src/mmps_pkg.sv
// Shared constants for the min-max partition search block.
`default_nettype none

package mmps_pkg;

  // Default sizes of the length store and of one length
  localparam int unsigned DEF_MAX_ELEMENTS = 1024;
  localparam int unsigned DEF_LENGTH_BITS  = 16;

  // Field widths of the result and of the cut limit register
  localparam int unsigned CUTS_W      = 10;
  localparam int unsigned OUT_W       = 26;
  localparam int unsigned OUT_TDATA_W = 32;

  // Register port
  localparam int unsigned APB_AW = 3;
  localparam int unsigned APB_DW = 32;

  // Register index, taken from paddr bit 2
  localparam logic REG_IDX_MAX_CUTS = 1'b0;

endpackage

`default_nettype wire

// File: src/mmps_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module mmps_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024
) (
  input  wire                                      clk_i,
  input  wire                                      we_i,
  input  wire  [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire  [WIDTH-1:0]                         wdata_i,
  input  wire  [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// File: src/min_max_partition_search.sv
// Min-max partition search: load a sequence, then binary-search the smallest segment limit.
//
// Input stream (s_axis_*): one length per beat in tdata, tlast marks the final element.
// Loading takes one beat per cycle; each length goes into the length store while the
// total and the largest length are kept. Elements past MAX_ELEMENTS are dropped and
// raise the overflow flag. After the tlast beat, tready stays low while the search runs.
// The search probes limits between the largest length and the total. Each probe walks
// the store once through a single add/compare unit fed by the RAM read port, and there
// are at most ceil(log2(total - largest + 2)) probes.
// Output stream (m_axis_*): one beat per sequence, the limit in tdata and the overflow
// flag in tuser. The result sits in an output register, so a new sequence can load
// while it waits; a further result waits until the receiver takes the previous one.
// Register max_cuts (byte address 0, APB) sets the allowed number of cuts.
// Reset clears the counters, flags and max_cuts; store contents are not cleared.
`default_nettype none

module min_max_partition_search #(
  parameter int unsigned MAX_ELEMENTS = mmps_pkg::DEF_MAX_ELEMENTS,
  parameter int unsigned LENGTH_BITS  = mmps_pkg::DEF_LENGTH_BITS
) (
  input  wire                                   clk_i,
  input  wire                                   rst_ni,
  // input stream; tdata: length
  input  wire                                   s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  wire  [((LENGTH_BITS + 7) / 8) * 8-1:0] s_axis_tdata,
  input  wire                                   s_axis_tlast,
  // result stream; tdata: min_max_sum, tuser: overflow
  output logic                                  m_axis_tvalid,
  input  wire                                   m_axis_tready,
  output logic [mmps_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
  output logic [0:0]                            m_axis_tuser,
  // register port
  input  wire                                   psel,
  input  wire                                   penable,
  input  wire                                   pwrite,
  input  wire  [mmps_pkg::APB_AW-1:0]           paddr,
  input  wire  [mmps_pkg::APB_DW-1:0]           pwdata,
  output logic [mmps_pkg::APB_DW-1:0]           prdata,
  output logic                                  pready
);

  import mmps_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_ELEMENTS + 1);
  localparam int unsigned AW    = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
  localparam int unsigned SUM_W = LENGTH_BITS + CNT_W;
  localparam int unsigned CMP_W = (CNT_W > CUTS_W) ? CNT_W : CUTS_W;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_INIT,
    ST_MID,
    ST_SCAN,
    ST_DECIDE,
    ST_DONE
  } state_e;

  state_e                 state_q, state_d;
  logic [CNT_W-1:0]       count_q, count_d;
  logic [SUM_W-1:0]       total_q, total_d;
  logic [LENGTH_BITS-1:0] largest_q, largest_d;
  logic                   ovf_q, ovf_d;
  logic [SUM_W-1:0]       low_q, low_d;
  logic [SUM_W-1:0]       high_q, high_d;
  logic [SUM_W-1:0]       best_q, best_d;
  logic [SUM_W-1:0]       mid_q, mid_d;
  logic [SUM_W-1:0]       seg_q, seg_d;
  logic [CNT_W-1:0]       cuts_q, cuts_d;
  logic [CNT_W-1:0]       rd_idx_q, rd_idx_d;
  logic                   dv_q, dv_d;
  logic [CUTS_W-1:0]      max_cuts_q, max_cuts_d;
  logic                   out_valid_q, out_valid_d;
  logic [OUT_W-1:0]       out_sum_q, out_sum_d;
  logic                   out_ovf_q, out_ovf_d;

  logic                   s_fire;
  logic                   m_fire;
  logic                   store_full;
  logic                   ram_we;
  logic [LENGTH_BITS-1:0] in_len;
  logic [LENGTH_BITS-1:0] ram_rdata;
  logic [SUM_W:0]         seg_add;
  logic                   seg_over;
  logic                   cuts_ok;
  logic                   cfg_wr;

  assign in_len     = s_axis_tdata[LENGTH_BITS-1:0];
  assign s_fire     = s_axis_tvalid && s_axis_tready;
  assign m_fire     = out_valid_q && m_axis_tready;
  assign store_full = (count_q == CNT_W'(MAX_ELEMENTS));
  assign ram_we     = s_fire && !store_full;

  // shared add/compare unit of the greedy walk
  assign seg_add  = {1'b0, seg_q} + (SUM_W + 1)'(ram_rdata);
  assign seg_over = seg_add > {1'b0, mid_q};
  assign cuts_ok  = CMP_W'(cuts_q) <= CMP_W'(max_cuts_q);

  // register port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_IDX_MAX_CUTS);
  assign prdata = (paddr[2] == REG_IDX_MAX_CUTS) ? APB_DW'(max_cuts_q) : '0;

  // stream outputs
  assign s_axis_tready = (state_q == ST_LOAD);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_TDATA_W'(out_sum_q);
  assign m_axis_tuser  = out_ovf_q;

  mmps_ram #(
    .WIDTH (LENGTH_BITS),
    .DEPTH (MAX_ELEMENTS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (count_q[AW-1:0]),
    .wdata_i (in_len),
    .raddr_i (rd_idx_q[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  // sequencer: load, then probe limits one store walk at a time
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    total_d     = total_q;
    largest_d   = largest_q;
    ovf_d       = ovf_q;
    low_d       = low_q;
    high_d      = high_q;
    best_d      = best_q;
    mid_d       = mid_q;
    seg_d       = seg_q;
    cuts_d      = cuts_q;
    rd_idx_d    = rd_idx_q;
    dv_d        = dv_q;
    max_cuts_d  = max_cuts_q;
    out_valid_d = out_valid_q;
    out_sum_d   = out_sum_q;
    out_ovf_d   = out_ovf_q;

    if (cfg_wr) begin
      max_cuts_d = pwdata[CUTS_W-1:0];
    end
    if (m_fire) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_LOAD: begin
        if (s_fire) begin
          if (!store_full) begin
            count_d = count_q + CNT_W'(1);
            total_d = total_q + SUM_W'(in_len);
            if (in_len > largest_q) begin
              largest_d = in_len;
            end
          end else begin
            ovf_d = 1'b1;
          end
          if (s_axis_tlast) begin
            state_d = ST_INIT;
          end
        end
      end
      ST_INIT: begin
        low_d   = SUM_W'(largest_q);
        high_d  = total_q;
        best_d  = total_q;
        state_d = ST_MID;
      end
      ST_MID: begin
        mid_d    = SUM_W'(({1'b0, low_q} + {1'b0, high_q}) >> 1);
        rd_idx_d = '0;
        dv_d     = 1'b0;
        seg_d    = '0;
        cuts_d   = '0;
        state_d  = ST_SCAN;
      end
      ST_SCAN: begin
        // issue one read per cycle, consume the data in the cycle after
        dv_d = rd_idx_q < count_q;
        if (rd_idx_q < count_q) begin
          rd_idx_d = rd_idx_q + CNT_W'(1);
        end
        if (dv_q) begin
          if (seg_over) begin
            cuts_d = cuts_q + CNT_W'(1);
            seg_d  = SUM_W'(ram_rdata);
          end else begin
            seg_d  = seg_add[SUM_W-1:0];
          end
        end else if (rd_idx_q == count_q) begin
          state_d = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        state_d = ST_MID;
        if (cuts_ok) begin
          best_d = mid_q;
          if (mid_q == low_q) begin
            state_d = ST_DONE;
          end else begin
            high_d = mid_q - SUM_W'(1);
          end
        end else begin
          low_d = mid_q + SUM_W'(1);
          if (mid_q == high_q) begin
            state_d = ST_DONE;
          end
        end
      end
      ST_DONE: begin
        // hand the result to the output register once it is free
        if (!out_valid_q || m_fire) begin
          out_valid_d = 1'b1;
          out_sum_d   = OUT_W'(best_q);
          out_ovf_d   = ovf_q;
          count_d     = '0;
          total_d     = '0;
          largest_d   = '0;
          ovf_d       = 1'b0;
          state_d     = ST_LOAD;
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      count_q     <= '0;
      total_q     <= '0;
      largest_q   <= '0;
      ovf_q       <= 1'b0;
      low_q       <= '0;
      high_q      <= '0;
      best_q      <= '0;
      mid_q       <= '0;
      seg_q       <= '0;
      cuts_q      <= '0;
      rd_idx_q    <= '0;
      dv_q        <= 1'b0;
      max_cuts_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      total_q     <= total_d;
      largest_q   <= largest_d;
      ovf_q       <= ovf_d;
      low_q       <= low_d;
      high_q      <= high_d;
      best_q      <= best_d;
      mid_q       <= mid_d;
      seg_q       <= seg_d;
      cuts_q      <= cuts_d;
      rd_idx_q    <= rd_idx_d;
      dv_q        <= dv_d;
      max_cuts_q  <= max_cuts_d;
      out_valid_q <= out_valid_d;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    out_sum_q <= out_sum_d;
    out_ovf_q <= out_ovf_d;
  end

`ifndef ASSERT_OFF
  // the final beat of a sequence starts the search, so loading must stop
  a_last_stops_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_fire && s_axis_tlast) |=> !s_axis_tready)
    else $error("input still accepted after final beat");

  // element count never runs past the store depth
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_ELEMENTS))
    else $error("element count beyond store depth");

  // probed limit stays inside the search window during a walk
  a_mid_in_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (low_q <= mid_q && mid_q <= high_q))
    else $error("probe limit outside search window");

  // a result only appears as the search hands off
  a_result_after_search: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(state_q == ST_DONE))
    else $error("result raised outside hand-off");
`endif

endmodule

`default_nettype wire

// File: sim/tb.sv
// Self-checking testbench for the min-max partition search block.
module tb;
  import mmps_pkg::*;

  localparam int unsigned DEPTH        = DEF_MAX_ELEMENTS;
  localparam int unsigned RANDOM_ITEMS = 1350;
  localparam int unsigned BIG_SEQ      = DEPTH + 2;   // two elements past a full store
  localparam int unsigned HOLD_CYCLES  = 3000;
  localparam int unsigned STALL_LIMIT  = 150000;
  localparam int unsigned DRAIN_CYCLES = 64;
  localparam int unsigned PLAN_ROWS    = 24;

  typedef struct packed {
    logic [OUT_W-1:0] sum;
    logic             ovf;
  } limit_t;

  // One directed beat; a row with pinned set carries its result typed in
  typedef struct packed {
    logic              set_cuts;
    logic [CUTS_W-1:0] cuts;
    logic [15:0]       len;
    logic              last;
    logic              pinned;
    logic [OUT_W-1:0]  sum;
  } step_t;

  logic               clk_i;
  logic               rst_ni;
  logic               s_axis_tvalid;
  logic               s_axis_tready;
  logic [15:0]        s_axis_tdata;   // length
  logic               s_axis_tlast;
  logic               m_axis_tvalid;
  logic               m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;  // min_max_sum, zero padding
  logic [0:0]         m_axis_tuser;   // overflow
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [APB_AW-1:0]  paddr;
  logic [APB_DW-1:0]  pwdata;
  logic [APB_DW-1:0]  prdata;
  logic               pready;

  // typed-in result that travels with the current beat
  logic               beat_pinned;
  logic [OUT_W-1:0]   beat_sum;

  // predictor state
  logic [15:0]        lengths [DEPTH];
  int unsigned        loaded;
  longint unsigned    total;
  logic [15:0]        largest;
  logic               dropped;
  logic [CUTS_W-1:0]  cuts_now;

  limit_t             due_limits [$];
  int unsigned        bad_count;
  int unsigned        results_seen;
  int unsigned        idle_cycles;
  bit                 src_calm;

  step_t plan [PLAN_ROWS] = '{
    '{1'b0, 10'd0,    16'd5,     1'b1, 1'b1, 26'd5},
    '{1'b0, 10'd0,    16'd0,     1'b1, 1'b1, 26'd0},
    '{1'b0, 10'd0,    16'd0,     1'b0, 1'b0, 26'd0},
    '{1'b0, 10'd0,    16'd0,     1'b0, 1'b0, 26'd0},
    '{1'b0, 10'd0,    16'd0,     1'b1, 1'b1, 26'd0},
    '{1'b0, 10'd0,    16'd65535, 1'b1, 1'b1, 26'd65535},
    '{1'b0, 10'd0,    16'd65535, 1'b0, 1'b0, 26'd0},
    '{1'b0, 10'd0,    16'd65535, 1'b1, 1'b1, 26'd131070},
    '{1'b1, 10'd1023, 16'd65535, 1'b0, 1'b0, 26'd0},
    '{1'b0, 10'd0,    16'd65535, 1'b0, 1'b0, 26'd0},
    '{1'b0, 10'd0,    16'd65535, 1'b1, 1'b1, 26'd65535},
    '{1'b0, 10'd0,    16'd0,     1'b0, 1'b0, 26'd0},
    '{1'b0, 10'd0,    16'd65535, 1'b0, 1'b0, 26'd0},
    '{1'b0, 10'd0,    16'd0,     1'b1, 1'b1, 26'd65535},
    '{1'b1, 10'd1,    16'd1,     1'b0, 1'b0, 26'd0},
    '{1'b0, 10'd0,    16'd2,     1'b0, 1'b0, 26'd0},
    '{1'b0, 10'd0,    16'd3,     1'b0, 1'b0, 26'd0},
    '{1'b0, 10'd0,    16'd4,     1'b0, 1'b0, 26'd0},
    '{1'b0, 10'd0,    16'd5,     1'b1, 1'b0, 26'd0},
    '{1'b0, 10'd0,    16'd32768, 1'b0, 1'b0, 26'd0},
    '{1'b0, 10'd0,    16'd1,     1'b1, 1'b1, 26'd32768},
    // cut limit changes while a sequence is half loaded
    '{1'b1, 10'd0,    16'd7,     1'b0, 1'b0, 26'd0},
    '{1'b0, 10'd0,    16'd9,     1'b0, 1'b0, 26'd0},
    '{1'b1, 10'd2,    16'd4,     1'b1, 1'b0, 26'd0}
  };

  min_max_partition_search i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 90);
  endfunction

  // Smallest limit under which a greedy split of the loaded lengths needs
  // no more than cuts_lim cuts
  function automatic logic [OUT_W-1:0] min_max_limit(input int unsigned n,
                                                     input longint unsigned sum_all,
                                                     input longint unsigned peak,
                                                     input int unsigned cuts_lim);
    longint lo;
    longint hi;
    longint mid;
    longint best;
    longint seg;
    int unsigned cuts_used;
    lo   = peak;
    hi   = sum_all;
    best = sum_all;
    while (lo <= hi) begin
      mid       = lo + (hi - lo) / 2;
      seg       = 0;
      cuts_used = 0;
      for (int i = 0; i < n; i++) begin
        if (seg + longint'(lengths[i]) > mid) begin
          cuts_used++;
          seg = lengths[i];
        end else begin
          seg += lengths[i];
        end
      end
      if (cuts_used <= cuts_lim) begin
        best = mid;
        hi   = mid - 1;
      end else begin
        lo = mid + 1;
      end
    end
    return best[OUT_W-1:0];
  endfunction

  // Offer one length beat after a random gap and hold it until taken
  task automatic send_beat(input logic [15:0] len, input logic last,
                           input logic pinned, input logic [OUT_W-1:0] sum);
    int unsigned gap;
    if ($urandom_range(0, 149) == 0) src_calm = !src_calm;
    gap = src_calm ? 0 : pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= len;
    s_axis_tlast  <= last;
    beat_pinned   <= pinned;
    beat_sum      <= sum;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // Wait until all results are in, then write max_cuts over APB
  task automatic load_cuts(input logic [CUTS_W-1:0] value);
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (due_limits.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_IDX_MAX_CUTS, 2'b00};
    pwdata  <= APB_DW'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Stimulus: directed table, then random sequences
  initial begin : stim_p
    int unsigned sent;
    int unsigned seqs;
    int unsigned n;
    int unsigned mode;
    int unsigned r;
    logic [15:0] len;
    logic [CUTS_W-1:0] cuts;
    bit big_done;
    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    beat_pinned   = 1'b0;
    beat_sum      = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    src_calm      = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) begin
      if (plan[i].set_cuts) load_cuts(plan[i].cuts);
      send_beat(plan[i].len, plan[i].last, plan[i].pinned, plan[i].sum);
    end

    sent     = 0;
    seqs     = 0;
    big_done = 1'b0;
    while (sent < RANDOM_ITEMS) begin
      // new cut limit every few sequences, extremes included
      if (seqs % 8 == 0) begin
        r = $urandom_range(0, 99);
        if (r < 15)      cuts = '0;
        else if (r < 30) cuts = '1;
        else if (r < 70) cuts = CUTS_W'($urandom_range(0, 7));
        else             cuts = CUTS_W'($urandom_range(0, 1023));
        load_cuts(cuts);
      end
      // one sequence runs past the store, the rest stay short
      if (!big_done && sent >= 300) begin
        n        = BIG_SEQ;
        mode     = 0;
        big_done = 1'b1;
      end else begin
        n    = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
        mode = $urandom_range(0, 2);
      end
      for (int k = 0; k < n; k++) begin
        case (mode)
          0: len = 16'($urandom_range(0, 65535));
          1: len = 16'($urandom_range(0, 15));
          default: len = ($urandom_range(0, 2) == 0) ? 16'd0 : 16'($urandom_range(0, 65535));
        endcase
        send_beat(len, k == n - 1, 1'b0, '0);
      end
      sent += n;
      seqs++;
    end
    s_axis_tvalid <= 1'b0;

    @(posedge clk_i);
    while (due_limits.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (bad_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Result side: random back-pressure plus one long hold-off
  initial begin : sink_p
    int unsigned stall;
    bit calm;
    bit held;
    stall         = 0;
    calm          = 1'b0;
    held          = 1'b0;
    m_axis_tready = 1'b0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (!held && results_seen >= 30) begin
        held = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else begin
        if ($urandom_range(0, 199) == 0) calm = !calm;
        if (stall > 0) begin
          m_axis_tready <= 1'b0;
          stall--;
        end else begin
          m_axis_tready <= 1'b1;
          if (!calm) stall = pick_gap();
        end
      end
    end
  end

  // Predictor update on accepted beats, compare on delivered results
  always @(posedge clk_i) begin : check_p
    limit_t want;
    if (rst_ni) begin
      if (psel && penable && pwrite && pready && paddr[2] == REG_IDX_MAX_CUTS)
        cuts_now = pwdata[CUTS_W-1:0];

      if (s_axis_tvalid && s_axis_tready) begin
        if (loaded < DEPTH) begin
          lengths[loaded] = s_axis_tdata;
          loaded++;
          total += s_axis_tdata;
          if (s_axis_tdata > largest) largest = s_axis_tdata;
        end else begin
          dropped = 1'b1;
        end
        if (s_axis_tlast) begin
          want.sum = beat_pinned ? beat_sum : min_max_limit(loaded, total, largest, cuts_now);
          want.ovf = beat_pinned ? 1'b0 : dropped;
          due_limits.push_back(want);
          loaded  = 0;
          total   = 0;
          largest = '0;
          dropped = 1'b0;
        end
      end

      if (m_axis_tvalid && m_axis_tready) begin
        results_seen++;
        if (due_limits.size() == 0) begin
          bad_count++;
          $display("%0t: unexpected result sum %0d overflow %0d", $time,
                   m_axis_tdata[OUT_W-1:0], m_axis_tuser[0]);
        end else begin
          want = due_limits.pop_front();
          if (m_axis_tdata[OUT_W-1:0] !== want.sum) begin
            bad_count++;
            $display("%0t: min_max_sum expected %0d got %0d", $time, want.sum,
                     m_axis_tdata[OUT_W-1:0]);
          end
          if (m_axis_tuser[0] !== want.ovf) begin
            bad_count++;
            $display("%0t: overflow expected %0d got %0d", $time, want.ovf,
                     m_axis_tuser[0]);
          end
        end
      end
    end
  end

  initial begin
    loaded       = 0;
    total        = 0;
    largest      = '0;
    dropped      = 1'b0;
    cuts_now     = '0;
    bad_count    = 0;
    results_seen = 0;
    idle_cycles  = 0;
  end

  // Watchdog: too long without any beat or register access
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (psel && penable && pready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

endmodule

// File: files.f
src/mmps_pkg.sv
src/mmps_ram.sv
src/min_max_partition_search.sv
sim/tb.sv
